>>> hw/rtl/gbkh2f_pkg.sv
// Shared types, byte constants and decode functions of the half-width to full-width converter.
package gbkh2f_pkg;

    // Byte values that the conversion rules compare against.
    localparam logic [7:0] ASCII_TOP      = 8'h80;
    localparam logic [7:0] FULL_LEAD      = 8'hA3;
    localparam logic [7:0] LEAD4_A_LO     = 8'h81;
    localparam logic [7:0] LEAD4_A_HI     = 8'h82;
    localparam logic [7:0] LEAD4_B_LO     = 8'h95;
    localparam logic [7:0] LEAD4_B_HI     = 8'h98;
    localparam logic [7:0] TRAIL_LO       = 8'h30;
    localparam logic [7:0] TRAIL2_TOP     = 8'h40;
    localparam logic [7:0] TRAIL4_HI      = 8'h39;
    localparam logic [7:0] MID_LO         = 8'h81;
    localparam logic [7:0] MID_HI         = 8'hFE;
    localparam logic [7:0] GB4_OUT_FIRST  = 8'h81;
    localparam logic [7:0] GB4_OUT_SECOND = 8'h30;

    localparam logic [15:0] CAP_RESET  = 16'd4096;
    localparam logic [16:0] CAP_MARGIN = 17'd4;
    localparam logic [15:0] EMIT_STEP  = 16'd2;
    localparam logic [15:0] POS_MAX    = 16'hFFFF;

    // Source bytes consumed by one character.
    localparam logic [2:0] TAKE_NONE = 3'd0;
    localparam logic [2:0] TAKE_ONE  = 3'd1;
    localparam logic [2:0] TAKE_PAIR = 3'd2;
    localparam logic [2:0] TAKE_QUAD = 3'd4;

    localparam logic [2:0] CNT_ZERO = 3'd0;
    localparam logic [2:0] CNT_ONE  = 3'd1;
    localparam logic [2:0] CNT_TWO  = 3'd2;
    localparam logic [2:0] CNT_FOUR = 3'd4;

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  first_byte;
        logic [7:0]  second_byte;
        logic [15:0] src_offset;
        logic [2:0]  src_length;
        logic [14:0] char_count;
        logic        truncated;
        logic        last_of_run;
    } t_out_item;

    // Class flags of one byte, worked out when the byte is taken in.
    typedef struct packed {
        logic ascii;   // below 0x80
        logic lead4;   // 81-82 or 95-98
        logic trail2;  // 30-3F
        logic mid;     // 81-FE
        logic trail4;  // 30-39
    } t_cls;

    typedef struct packed {
        t_cls       cls;
        logic [7:0] value;
    } t_byte;

    typedef t_byte [3:0] t_bbuf;

    typedef struct packed {
        t_in_item item;
        t_cls     cls;
    } t_qent;

    // Head of the queue between front and back.
    typedef struct packed {
        logic  valid;
        t_qent ent;
    } t_qhead;

    typedef struct packed {
        logic       stop;
        logic       emit;
        logic [2:0] take;
        logic [7:0] o1;
        logic [7:0] o2;
    } t_dec;

    function automatic t_cls classify(input logic [7:0] b);
        t_cls c;
        c.ascii  = (b < ASCII_TOP);
        c.lead4  = ((b >= LEAD4_A_LO) && (b <= LEAD4_A_HI)) ||
                   ((b >= LEAD4_B_LO) && (b <= LEAD4_B_HI));
        c.trail2 = (b >= TRAIL_LO) && (b < TRAIL2_TOP);
        c.mid    = (b >= MID_LO) && (b <= MID_HI);
        c.trail4 = (b >= TRAIL_LO) && (b <= TRAIL4_HI);
        return c;
    endfunction

    // One decision of the conversion loop on the buffered bytes.
    function automatic t_dec decide(input t_bbuf b, input logic [2:0] n, input logic last,
                                    input logic [15:0] emitted, input logic [15:0] cap);
        t_dec d;
        logic [2:0] take;
        d = '0;
        take = TAKE_PAIR;
        if (n != CNT_ZERO) begin
            if (({1'b0, emitted} + CAP_MARGIN) > {1'b0, cap}) begin
                d.stop = 1'b1;
            end else if (b[0].cls.ascii) begin
                d.emit = 1'b1;
                d.take = TAKE_ONE;
                d.o1   = FULL_LEAD;
                d.o2   = b[0].value + ASCII_TOP;
            end else if (n >= CNT_TWO) begin
                if (b[0].cls.lead4 && b[1].cls.trail2) begin
                    if (n < 3'd3) begin
                        if (!last) take = TAKE_NONE;
                    end else if (b[2].cls.mid) begin
                        if (n < CNT_FOUR) begin
                            if (!last) take = TAKE_NONE;
                        end else if (b[3].cls.trail4) begin
                            take = TAKE_QUAD;
                        end
                    end
                end
                if (take != TAKE_NONE) begin
                    d.emit = 1'b1;
                    d.take = take;
                    d.o1   = (take == TAKE_QUAD) ? GB4_OUT_FIRST : b[0].value;
                    d.o2   = (take == TAKE_QUAD) ? GB4_OUT_SECOND : b[1].value;
                end
            end
        end
        return d;
    endfunction

endpackage

>>> hw/rtl/gbk_half_to_full_width.sv
// Top level of the half-width to full-width converter: capacity register, front, back.
// Latency: the first result of a byte is held in a queue entry, then in the output register.
// Throughput: one byte per cycle while each byte yields at most one result and the output is
// not stalled; a byte with more results holds the back sequencer for one decision per result.
// Reset (synchronous, active low) empties the queue and output register, clears the string
// state and sets the capacity to 4096; the pending byte storage is left as it is.
module gbk_half_to_full_width (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  gbkh2f_pkg::t_in_item  i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output gbkh2f_pkg::t_out_item o_out,
    input  logic                  i_cfg_we,
    input  logic [15:0]           i_cfg_data
);

    logic [15:0]        r_cap;
    gbkh2f_pkg::t_qhead head;
    logic               pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= gbkh2f_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    gbkh2f_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_head     (head),
        .i_pop      (pop)
    );

    gbkh2f_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .i_cap       (r_cap),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // A summary always closes the run of its byte.
    a_summary_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.kind == gbkh2f_pkg::KIND_SUMMARY)) |-> o_out.last_of_run)
        else $error("summary result without last_of_run");

    a_char_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.kind == gbkh2f_pkg::KIND_CHAR)) |->
        ((o_out.src_length == gbkh2f_pkg::TAKE_ONE) ||
         (o_out.src_length == gbkh2f_pkg::TAKE_PAIR) ||
         (o_out.src_length == gbkh2f_pkg::TAKE_QUAD)))
        else $error("character result with bad source length");

    a_summary_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.kind == gbkh2f_pkg::KIND_SUMMARY)) |->
        ((o_out.first_byte == 8'd0) && (o_out.src_offset == 16'd0) &&
         (o_out.src_length == gbkh2f_pkg::TAKE_NONE)))
        else $error("summary result carries character fields");

    // A queue pop only happens when the queue holds an entry.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head.valid)
        else $error("queue popped while empty");

endmodule

>>> hw/rtl/gbkh2f_front.sv
// Front part: accepts input bytes, classifies them and queues them for the back part.
module gbkh2f_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  gbkh2f_pkg::t_in_item  i_in,
    output gbkh2f_pkg::t_qhead    o_head,
    input  logic                  i_pop
);

    gbkh2f_pkg::t_qent r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;

    assign o_in_ready = (r_count != 2'd2);
    assign push       = i_in_valid && o_in_ready;

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.ent   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= !r_wr_ptr;
            if (i_pop) r_rd_ptr <= !r_rd_ptr;
            r_count <= r_count + {1'b0, push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr].item <= i_in;
            r_mem[r_wr_ptr].cls  <= gbkh2f_pkg::classify(i_in.in_byte);
        end
    end

endmodule

>>> hw/rtl/gbkh2f_back.sv
// Back part: runs the conversion loop into the output register, one decision per cycle while the output is free.
module gbkh2f_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  gbkh2f_pkg::t_qhead    i_head,
    output logic                  o_pop,
    input  logic [15:0]           i_cap,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output gbkh2f_pkg::t_out_item o_out
);

    gbkh2f_pkg::t_bbuf     r_buf, n_buf;
    logic [2:0]            r_n, n_n;
    logic                  r_busy, n_busy;
    logic                  r_last, n_last;
    logic                  r_stopped, n_stopped;
    logic [15:0]           r_pos, n_pos;
    logic [15:0]           r_emit, n_emit;
    logic                  r_out_valid, n_out_valid;
    gbkh2f_pkg::t_out_item r_out, n_out;

    gbkh2f_pkg::t_bbuf vbuf, rbuf;
    logic [2:0]        vn, rn;
    logic              vlast, active, from_q, out_free, step;
    gbkh2f_pkg::t_dec  d1, d2;
    logic [16:0]       pos_sum;
    gbkh2f_pkg::t_out_item summary;

    assign out_free = !r_out_valid || i_out_ready;

    // The working view: a string in progress, or the pending bytes plus the queue head.
    always_comb begin
        vbuf = r_buf;
        if (r_busy) begin
            vn     = r_n;
            vlast  = r_last;
            active = 1'b1;
            from_q = 1'b0;
        end else begin
            if (!r_stopped) vbuf[r_n[1:0]] = {i_head.ent.cls, i_head.ent.item.in_byte};
            vn     = r_stopped ? r_n : r_n + 3'd1;
            vlast  = i_head.ent.item.is_last;
            active = i_head.valid;
            from_q = 1'b1;
        end
    end

    assign step  = active && out_free;
    assign o_pop = step && from_q;

    assign d1 = gbkh2f_pkg::decide(vbuf, vn, vlast, r_emit, i_cap);

    always_comb begin
        rbuf = vbuf;
        unique case (d1.take)
            gbkh2f_pkg::TAKE_ONE: begin
                rbuf[0] = vbuf[1];
                rbuf[1] = vbuf[2];
                rbuf[2] = vbuf[3];
            end
            gbkh2f_pkg::TAKE_PAIR: begin
                rbuf[0] = vbuf[2];
                rbuf[1] = vbuf[3];
            end
            default: ;
        endcase
    end

    assign rn = vn - d1.take;

    // Looking one decision ahead tells whether this character closes the run.
    assign d2 = gbkh2f_pkg::decide(rbuf, rn, vlast, r_emit + gbkh2f_pkg::EMIT_STEP, i_cap);

    assign pos_sum = {1'b0, r_pos} + {14'd0, d1.take};

    always_comb begin
        summary             = '0;
        summary.kind        = gbkh2f_pkg::KIND_SUMMARY;
        summary.char_count  = r_emit[15:1];
        summary.truncated   = r_stopped || d1.stop;
        summary.last_of_run = 1'b1;
    end

    always_comb begin
        n_buf       = r_buf;
        n_n         = r_n;
        n_busy      = r_busy;
        n_last      = r_last;
        n_stopped   = r_stopped;
        n_pos       = r_pos;
        n_emit      = r_emit;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        if (step) begin
            n_last = vlast;
            if (!r_stopped && d1.emit) begin
                n_out_valid             = 1'b1;
                n_out                   = '0;
                n_out.kind              = gbkh2f_pkg::KIND_CHAR;
                n_out.first_byte        = d1.o1;
                n_out.second_byte       = d1.o2;
                n_out.src_offset        = r_pos;
                n_out.src_length        = d1.take;
                n_out.last_of_run       = !vlast && !d2.emit;
                n_emit                  = r_emit + gbkh2f_pkg::EMIT_STEP;
                n_pos                   = pos_sum[16] ? gbkh2f_pkg::POS_MAX : pos_sum[15:0];
                n_buf                   = rbuf;
                n_n                     = rn;
                n_busy                  = vlast || d2.emit;
                if (!vlast && d2.stop) begin
                    n_stopped = 1'b1;
                    n_n       = gbkh2f_pkg::CNT_ZERO;
                end
            end else if (vlast) begin
                // End of string: summary result and a clean start for the next string.
                n_out_valid = 1'b1;
                n_out       = summary;
                n_pos       = '0;
                n_emit      = '0;
                n_stopped   = 1'b0;
                n_n         = gbkh2f_pkg::CNT_ZERO;
                n_busy      = 1'b0;
            end else begin
                n_busy = 1'b0;
                if (r_stopped || d1.stop) begin
                    n_stopped = 1'b1;
                    n_n       = gbkh2f_pkg::CNT_ZERO;
                end else begin
                    n_buf = vbuf;
                    n_n   = vn;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n         <= gbkh2f_pkg::CNT_ZERO;
            r_busy      <= 1'b0;
            r_last      <= 1'b0;
            r_stopped   <= 1'b0;
            r_pos       <= '0;
            r_emit      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_n         <= n_n;
            r_busy      <= n_busy;
            r_last      <= n_last;
            r_stopped   <= n_stopped;
            r_pos       <= n_pos;
            r_emit      <= n_emit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the half-width to full-width byte string converter.
module testbench;

    localparam int RANDOM_ITEMS  = 320;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int FILL_QUADS    = 4;
    localparam int FILL_ASCII    = 8;
    localparam int FILL_CAP      = 20;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    gbkh2f_pkg::t_in_item  in_item = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [15:0]           cfg_data = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    gbkh2f_pkg::t_out_item o_out;

    // Converter state as the checker sees it.
    logic [7:0] held_bytes [3];
    int         held_cnt = 0;
    int         char_pos = 0;
    int         out_bytes_used = 0;
    logic       halted = 1'b0;
    int         capacity = int'(gbkh2f_pkg::CAP_RESET);

    gbkh2f_pkg::t_in_item  bytes_to_send [$];
    gbkh2f_pkg::t_in_item  text_stream [$];
    gbkh2f_pkg::t_out_item expected_chars [$];

    int in_max_gap = 0;
    int out_max_gap = 0;
    int in_wait = 0;
    int out_wait = 0;
    int quiet_cycles = 0;
    int results_seen = 0;
    int error_count = 0;

    gbk_half_to_full_width dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", results_seen, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    // Works out the characters that one accepted byte releases.
    task automatic convert_byte(input gbkh2f_pkg::t_in_item it);
        logic [7:0]            pend [4];
        gbkh2f_pkg::t_out_item run_res [$];
        gbkh2f_pkg::t_out_item r;
        logic [7:0]            b1, b2, o1, o2;
        logic [2:0]            take;
        logic                  waiting;
        int                    n, i;
        n = held_cnt;
        for (i = 0; i < n; i++) pend[i] = held_bytes[i];
        waiting = 1'b0;
        if (!halted) begin
            pend[n] = it.in_byte;
            n++;
            while (n > 0 && !waiting) begin
                b1 = pend[0];
                b2 = '0;
                o1 = '0;
                o2 = '0;
                take = gbkh2f_pkg::TAKE_NONE;
                if (out_bytes_used + 4 > capacity) begin
                    halted = 1'b1;
                    n = 0;
                end else if (b1 < gbkh2f_pkg::ASCII_TOP) begin
                    take = gbkh2f_pkg::TAKE_ONE;
                    o1 = gbkh2f_pkg::FULL_LEAD;
                    o2 = b1 + gbkh2f_pkg::ASCII_TOP;
                end else if (n < 2) begin
                    // A lead byte waits for its partner and is dropped at the end of a string.
                    if (it.is_last) n = 0;
                    waiting = 1'b1;
                end else begin
                    b2 = pend[1];
                    take = gbkh2f_pkg::TAKE_PAIR;
                    if (((b1 >= gbkh2f_pkg::LEAD4_A_LO && b1 <= gbkh2f_pkg::LEAD4_A_HI) ||
                         (b1 >= gbkh2f_pkg::LEAD4_B_LO && b1 <= gbkh2f_pkg::LEAD4_B_HI)) &&
                        b2 >= gbkh2f_pkg::TRAIL_LO && b2 < gbkh2f_pkg::TRAIL2_TOP) begin
                        if (n < 3) begin
                            if (!it.is_last) take = gbkh2f_pkg::TAKE_NONE;
                        end else if (pend[2] >= gbkh2f_pkg::MID_LO &&
                                     pend[2] <= gbkh2f_pkg::MID_HI) begin
                            if (n < 4) begin
                                if (!it.is_last) take = gbkh2f_pkg::TAKE_NONE;
                            end else if (pend[3] >= gbkh2f_pkg::TRAIL_LO &&
                                         pend[3] <= gbkh2f_pkg::TRAIL4_HI) begin
                                take = gbkh2f_pkg::TAKE_QUAD;
                            end
                        end
                    end
                    if (take == gbkh2f_pkg::TAKE_NONE) begin
                        waiting = 1'b1;
                    end else if (take == gbkh2f_pkg::TAKE_QUAD) begin
                        o1 = gbkh2f_pkg::GB4_OUT_FIRST;
                        o2 = gbkh2f_pkg::GB4_OUT_SECOND;
                    end else begin
                        o1 = b1;
                        o2 = b2;
                    end
                end
                if (take != gbkh2f_pkg::TAKE_NONE) begin
                    r = '0;
                    r.kind = gbkh2f_pkg::KIND_CHAR;
                    r.first_byte = o1;
                    r.second_byte = o2;
                    r.src_offset = 16'(char_pos);
                    r.src_length = take;
                    run_res.push_back(r);
                    out_bytes_used += 2;
                    char_pos = (char_pos + int'(take) > int'(gbkh2f_pkg::POS_MAX)) ?
                               int'(gbkh2f_pkg::POS_MAX) : char_pos + int'(take);
                    for (i = int'(take); i < n; i++) pend[i - int'(take)] = pend[i];
                    n -= int'(take);
                end
            end
        end
        if (it.is_last) begin
            r = '0;
            r.kind = gbkh2f_pkg::KIND_SUMMARY;
            r.char_count = 15'(out_bytes_used / 2);
            r.truncated = halted;
            run_res.push_back(r);
            char_pos = 0;
            out_bytes_used = 0;
            halted = 1'b0;
            n = 0;
        end
        if (halted) n = 0;
        for (i = 0; i < n; i++) held_bytes[i] = pend[i];
        held_cnt = n;
        if (run_res.size() != 0) begin
            r = run_res.pop_back();
            r.last_of_run = 1'b1;
            run_res.push_back(r);
        end
        while (run_res.size() != 0) expected_chars.push_back(run_res.pop_front());
    endtask

    task automatic check_result(input gbkh2f_pkg::t_out_item got);
        gbkh2f_pkg::t_out_item want;
        results_seen++;
        if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("no result pending, got kind %0d bytes %h %h",
                                      got.kind, got.first_byte, got.second_byte));
        end else begin
            want = expected_chars.pop_front();
            check_field("kind", 16'(got.kind), 16'(want.kind));
            check_field("first_byte", 16'(got.first_byte), 16'(want.first_byte));
            check_field("second_byte", 16'(got.second_byte), 16'(want.second_byte));
            check_field("src_offset", got.src_offset, want.src_offset);
            check_field("src_length", 16'(got.src_length), 16'(want.src_length));
            check_field("char_count", 16'(got.char_count), 16'(want.char_count));
            check_field("truncated", 16'(got.truncated), 16'(want.truncated));
            check_field("last_of_run", 16'(got.last_of_run), 16'(want.last_of_run));
        end
    endtask

    always @(posedge i_clk) begin : byte_driver
        logic holding;
        holding = in_valid && !o_in_ready;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_wait <= 0;
        end else begin
            if (in_valid && o_in_ready) convert_byte(in_item);
            if (!holding) begin
                if (in_wait != 0) begin
                    in_valid <= 1'b0;
                    in_wait <= in_wait - 1;
                end else if (bytes_to_send.size() != 0) begin
                    in_item <= bytes_to_send.pop_front();
                    in_valid <= 1'b1;
                    in_wait <= $urandom_range(in_max_gap, 0);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        int w;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            out_wait <= 0;
        end else if (o_out_valid && out_ready) begin
            check_result(o_out);
            w = $urandom_range(out_max_gap, 0);
            out_wait <= w;
            out_ready <= (w == 0);
        end else if (out_wait != 0) begin
            out_wait <= out_wait - 1;
            out_ready <= (out_wait == 1);
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [7:0] rand_byte(input int lo, input int hi);
        return 8'($urandom_range(hi, lo));
    endfunction

    function automatic logic [7:0] pick_lead4();
        int k;
        k = $urandom_range(5, 0);
        return (k < 2) ? gbkh2f_pkg::LEAD4_A_LO + 8'(k) : gbkh2f_pkg::LEAD4_B_LO + 8'(k - 2);
    endfunction

    function automatic int pick_gap();
        int k;
        k = $urandom_range(2, 0);
        return (k == 0) ? 0 : (k == 1) ? 3 : 12;
    endfunction

    task automatic queue_byte(input logic [7:0] b, input logic last);
        gbkh2f_pkg::t_in_item it;
        it.in_byte = b;
        it.is_last = last;
        bytes_to_send.push_back(it);
    endtask

    // Mostly well-formed characters, with broken four-byte candidates and noise mixed in.
    task automatic add_string();
        logic [7:0]           s [$];
        gbkh2f_pkg::t_in_item it;
        int                   chars, c;
        chars = $urandom_range(10, 1);
        for (c = 0; c < chars; c++) begin
            case ($urandom_range(9, 0))
                0, 1, 2: s.push_back(rand_byte('h01, 'h7F));
                3, 4: begin
                    s.push_back(rand_byte('h81, 'hFE));
                    s.push_back(rand_byte('h01, 'hFF));
                end
                5, 6: begin
                    s.push_back(pick_lead4());
                    s.push_back(rand_byte('h30, 'h39));
                    s.push_back(rand_byte('h81, 'hFE));
                    s.push_back(rand_byte('h30, 'h39));
                end
                7: begin
                    s.push_back(pick_lead4());
                    s.push_back(rand_byte('h30, 'h3F));
                    s.push_back(rand_byte('h01, 'hFF));
                end
                8: s.push_back(rand_byte('h01, 'hFF));
                default: begin
                    s.push_back(pick_lead4());
                    s.push_back(rand_byte('h30, 'h3F));
                    s.push_back(rand_byte('h81, 'hFE));
                    s.push_back(rand_byte('h01, 'hFF));
                end
            endcase
        end
        if ($urandom_range(5, 0) == 0) s.push_back(rand_byte('h80, 'hFF));
        while (s.size() != 0) begin
            it.in_byte = s.pop_front();
            it.is_last = (s.size() == 0);
            text_stream.push_back(it);
        end
    endtask

    // Waits until every byte is in and every result is out, then lets the pipeline settle.
    task automatic drain();
        @(negedge i_clk);
        while (bytes_to_send.size() != 0 || in_valid || expected_chars.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_capacity(input int v);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_data <= 16'(v);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        capacity = v;
        @(negedge i_clk);
    endtask

    initial begin
        int total, chunk, i, cap;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Byte extremes, the zero byte, and quads at both lead ranges under reset capacity.
        in_max_gap = 12;
        out_max_gap = 12;
        queue_byte(8'h00, 1'b0); queue_byte(8'h01, 1'b0); queue_byte(8'h7F, 1'b0);
        queue_byte(8'hFF, 1'b0); queue_byte(8'hFF, 1'b0);
        queue_byte(8'h81, 1'b0); queue_byte(8'h30, 1'b0);
        queue_byte(8'h81, 1'b0); queue_byte(8'h30, 1'b0);
        queue_byte(8'h98, 1'b0); queue_byte(8'h3F, 1'b0);
        queue_byte(8'hFE, 1'b0); queue_byte(8'h39, 1'b1);
        // A quad from the first lead range, a two-byte pair, then a lone lead at the end.
        queue_byte(8'h82, 1'b0); queue_byte(8'h30, 1'b0); queue_byte(8'h96, 1'b0);
        queue_byte(8'h35, 1'b0); queue_byte(8'h90, 1'b0); queue_byte(8'h40, 1'b0);
        queue_byte(8'hC0, 1'b1);
        // A candidate cut short by the end of the string.
        queue_byte(8'h81, 1'b0); queue_byte(8'h35, 1'b0); queue_byte(8'hA0, 1'b1);
        drain();

        // Capacity shrinks in the middle of a string, so the third character no longer fits.
        set_capacity(8);
        queue_byte(8'h41, 1'b0); queue_byte(8'h42, 1'b0);
        drain();
        set_capacity(6);
        queue_byte(8'h43, 1'b0); queue_byte(8'h44, 1'b1);
        drain();

        total = 0;
        while (total < RANDOM_ITEMS) begin
            case ($urandom_range(5, 0))
                0: cap = 0;
                1: cap = int'(gbkh2f_pkg::POS_MAX);
                2: cap = $urandom_range(12, 1);
                3, 4: cap = $urandom_range(80, 13);
                default: cap = int'(gbkh2f_pkg::CAP_RESET);
            endcase
            set_capacity(cap);
            in_max_gap = pick_gap();
            out_max_gap = pick_gap();
            chunk = $urandom_range(55, 15);
            for (i = 0; i < chunk; i++) begin
                if (text_stream.size() == 0) add_string();
                bytes_to_send.push_back(text_stream.pop_front());
            end
            total += chunk;
            drain();
        end
        while (text_stream.size() != 0) bytes_to_send.push_back(text_stream.pop_front());
        drain();

        // One string at full rate: quads, then single bytes until the buffer fills up.
        set_capacity(FILL_CAP);
        in_max_gap = 0;
        out_max_gap = 0;
        for (i = 0; i < FILL_QUADS; i++) begin
            queue_byte(gbkh2f_pkg::LEAD4_A_LO, 1'b0); queue_byte(gbkh2f_pkg::TRAIL_LO, 1'b0);
            queue_byte(gbkh2f_pkg::MID_LO, 1'b0); queue_byte(gbkh2f_pkg::TRAIL_LO, 1'b0);
        end
        for (i = 0; i < FILL_ASCII; i++) queue_byte(8'h41, 1'b0);
        queue_byte(8'h42, 1'b1);
        drain();

        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
